[hw/rtl/stvk_triangle_energy_gradient_unit_assert.svh]
// Assertion macros for the StVK triangle gradient unit.
`ifndef STVK_TRIANGLE_ENERGY_GRADIENT_UNIT_ASSERT_SVH
`define STVK_TRIANGLE_ENERGY_GRADIENT_UNIT_ASSERT_SVH
`define STVK_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define STVK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

[hw/rtl/stvk_pkg.sv]
// Package: widths, pipeline depth and fixed-point helpers for the StVK unit.
`default_nettype none
package stvk_pkg;
   localparam int FRAC_BITS = 16;
   localparam int DW = 32;
   localparam int RW = 31;
   localparam int LATENCY = 17;
   localparam logic [0:0] CSR_SHEAR = 1'd0;
   localparam logic [0:0] CSR_LAMBDA = 1'd1;

   typedef logic signed [DW-1:0] word_type;
   typedef logic signed [63:0] wide_type;

   // round to nearest, ties up, at s fraction bits
   function automatic wide_type rshr(input wide_type v, input int s);
      wide_type t;
      t = v + (64'sd1 <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic wide_type rmul(input wide_type a, input wide_type b);
      return rshr(a * b, FRAC_BITS);
   endfunction

   function automatic word_type sat32(input wide_type v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[DW-1:0];
   endfunction

   function automatic wide_type sx(input word_type v);
      return 64'(v);
   endfunction
endpackage
`default_nettype wire

[hw/rtl/stvk_triangle_energy_gradient_unit.sv]
// Top level: StVK triangle energy and vertex gradient, fully pipelined.
// One triangle may be started every cycle (start while busy is low; busy is
// never raised). The result appears rsp_valid-strobed at the end of the
// pipeline. The arithmetic takes thirteen register stages, one multiply
// level or one sum/saturate level each: F, G, trace, stress bracket, P,
// area*P, H and the v2 sum, with the energy terms alongside.
// Four more output registers pad the total to LATENCY. The receiver cannot
// stall; each result is shown for one cycle only.
`default_nettype none
module stvk_triangle_energy_gradient_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire  signed [31:0]       req_edge_a_x,
   input  wire  signed [31:0]       req_edge_a_y,
   input  wire  signed [31:0]       req_edge_a_z,
   input  wire  signed [31:0]       req_edge_b_x,
   input  wire  signed [31:0]       req_edge_b_y,
   input  wire  signed [31:0]       req_edge_b_z,
   input  wire  signed [31:0]       req_inv_rest_00,
   input  wire  signed [31:0]       req_inv_rest_01,
   input  wire  signed [31:0]       req_inv_rest_10,
   input  wire  signed [31:0]       req_inv_rest_11,
   input  wire         [30:0]       req_rest_area,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_grad_v0_x,
   output logic signed [31:0]       rsp_grad_v0_y,
   output logic signed [31:0]       rsp_grad_v0_z,
   output logic signed [31:0]       rsp_grad_v1_x,
   output logic signed [31:0]       rsp_grad_v1_y,
   output logic signed [31:0]       rsp_grad_v1_z,
   output logic signed [31:0]       rsp_grad_v2_x,
   output logic signed [31:0]       rsp_grad_v2_y,
   output logic signed [31:0]       rsp_grad_v2_z,
   output logic        [30:0]       rsp_elastic_energy,
   input  wire                      csr_we,
   input  wire         [0:0]        csr_index,
   input  wire         [30:0]       csr_wdata
);
   import stvk_pkg::*;

   logic [30:0] mu_ff, lam_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff <= 31'(1 << FRAC_BITS);
         lam_ff <= 31'(1 << FRAC_BITS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHEAR: mu_ff <= csr_wdata;
            CSR_LAMBDA: lam_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   wire go = start & ~busy;

   // valid shift line
   logic [LATENCY-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LATENCY-2:0], go};
   end
   assign rsp_valid = vld_ff[LATENCY-1];

   // carried operands: entry k is aligned with vld_ff[k]
   word_type d_ff [10][4];
   logic [30:0] ar_ff [9];
   always_ff @(posedge clock) begin
      d_ff[0][0] <= req_inv_rest_00; d_ff[0][1] <= req_inv_rest_01;
      d_ff[0][2] <= req_inv_rest_10; d_ff[0][3] <= req_inv_rest_11;
      ar_ff[0] <= req_rest_area;
      for (int k = 1; k < 10; k++) d_ff[k] <= d_ff[k-1];
      for (int k = 1; k < 9; k++) ar_ff[k] <= ar_ff[k-1];
   end

   // S1: F products
   wide_type fp_ff [3][4];
   word_type ea [3], eb [3];
   assign ea[0] = req_edge_a_x; assign ea[1] = req_edge_a_y; assign ea[2] = req_edge_a_z;
   assign eb[0] = req_edge_b_x; assign eb[1] = req_edge_b_y; assign eb[2] = req_edge_b_z;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         fp_ff[i][0] <= rmul(sx(ea[i]), sx(req_inv_rest_00));
         fp_ff[i][1] <= rmul(sx(eb[i]), sx(req_inv_rest_10));
         fp_ff[i][2] <= rmul(sx(ea[i]), sx(req_inv_rest_01));
         fp_ff[i][3] <= rmul(sx(eb[i]), sx(req_inv_rest_11));
      end
   end
   // S2: F, carried until the P products
   word_type f_ff [1:6][3][2];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         f_ff[1][i][0] <= sat32(fp_ff[i][0] + fp_ff[i][1]);
         f_ff[1][i][1] <= sat32(fp_ff[i][2] + fp_ff[i][3]);
      end
      for (int k = 2; k < 7; k++) f_ff[k] <= f_ff[k-1];
   end
   // S3: F^T F products (00,01,11)
   wide_type gp_ff [3][3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         gp_ff[0][i] <= rmul(sx(f_ff[1][i][0]), sx(f_ff[1][i][0]));
         gp_ff[1][i] <= rmul(sx(f_ff[1][i][0]), sx(f_ff[1][i][1]));
         gp_ff[2][i] <= rmul(sx(f_ff[1][i][1]), sx(f_ff[1][i][1]));
      end
   end
   // S4: G
   word_type g_ff [3];
   wide_type one_w;
   assign one_w = 64'sd1 <<< FRAC_BITS;
   always_ff @(posedge clock) begin
      g_ff[0] <= sat32(rshr(gp_ff[0][0] + gp_ff[0][1] + gp_ff[0][2] - one_w, 1));
      g_ff[1] <= sat32(rshr(gp_ff[1][0] + gp_ff[1][1] + gp_ff[1][2], 1));
      g_ff[2] <= sat32(rshr(gp_ff[2][0] + gp_ff[2][1] + gp_ff[2][2] - one_w, 1));
   end
   // S5: trace; carry G
   word_type tr_ff, g5_ff [3];
   always_ff @(posedge clock) begin
      tr_ff <= sat32(sx(g_ff[0]) + sx(g_ff[2]));
      g5_ff <= g_ff;
   end
   // S6: bracket products and energy squares
   wide_type mg_ff [3], lt_ff, nq_ff [3], tq_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mg_ff[i] <= rmul(64'(mu_ff), sx(g5_ff[i]));
         nq_ff[i] <= rmul(sx(g5_ff[i]), sx(g5_ff[i]));
      end
      lt_ff <= rmul(64'(lam_ff), sx(tr_ff));
      tq_ff <= rmul(sx(tr_ff), sx(tr_ff));
   end
   // S7: bracket M (00,01=10,11), |G|^2, tr^2
   word_type m_ff [3], n2_ff, ts_ff;
   always_ff @(posedge clock) begin
      m_ff[0] <= sat32(2 * mg_ff[0] + lt_ff);
      m_ff[1] <= sat32(2 * mg_ff[1]);
      m_ff[2] <= sat32(2 * mg_ff[2] + lt_ff);
      n2_ff <= sat32(nq_ff[0] + 2 * nq_ff[1] + nq_ff[2]);
      ts_ff <= sat32(tq_ff);
   end
   // S8: P products; energy density products
   wide_type pp_ff [3][4], ed0_ff, ed1_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pp_ff[i][0] <= rmul(sx(f_ff[6][i][0]), sx(m_ff[0]));
         pp_ff[i][1] <= rmul(sx(f_ff[6][i][1]), sx(m_ff[1]));
         pp_ff[i][2] <= rmul(sx(f_ff[6][i][0]), sx(m_ff[1]));
         pp_ff[i][3] <= rmul(sx(f_ff[6][i][1]), sx(m_ff[2]));
      end
      ed0_ff <= rmul(64'(mu_ff), sx(n2_ff));
      ed1_ff <= rshr(64'(lam_ff) * sx(ts_ff), FRAC_BITS + 1);
   end
   // S9: P, density
   word_type p_ff [3][2], dn_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         p_ff[i][0] <= sat32(pp_ff[i][0] + pp_ff[i][1]);
         p_ff[i][1] <= sat32(pp_ff[i][2] + pp_ff[i][3]);
      end
      dn_ff <= sat32(ed0_ff + ed1_ff);
   end
   // S10: area*P, area*density
   word_type q_ff [3][2];
   wide_type en_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 2; j++)
            q_ff[i][j] <= sat32(rmul(64'(ar_ff[8]), sx(p_ff[i][j])));
      en_ff <= rmul(64'(ar_ff[8]), sx(dn_ff));
   end
   // S11: H products
   wide_type hp_ff [3][4];
   logic [30:0] e11_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         hp_ff[i][0] <= rmul(sx(q_ff[i][0]), sx(d_ff[9][0]));
         hp_ff[i][1] <= rmul(sx(q_ff[i][1]), sx(d_ff[9][1]));
         hp_ff[i][2] <= rmul(sx(q_ff[i][0]), sx(d_ff[9][2]));
         hp_ff[i][3] <= rmul(sx(q_ff[i][1]), sx(d_ff[9][3]));
      end
      if (en_ff < 0) e11_ff <= '0;
      else if (en_ff > 64'sh7fffffff) e11_ff <= 31'h7fffffff;
      else e11_ff <= en_ff[30:0];
   end
   // S12: H
   word_type h_ff [3][2];
   logic [30:0] e12_ff;
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         h_ff[i][0] <= sat32(hp_ff[i][0] + hp_ff[i][1]);
         h_ff[i][1] <= sat32(hp_ff[i][2] + hp_ff[i][3]);
      end
      e12_ff <= e11_ff;
   end
   // S13: v2 term; then delay to LATENCY
   localparam int TAIL = LATENCY - 12;
   word_type o_ff [TAIL][9];
   logic [30:0] eo_ff [TAIL];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         o_ff[0][i] <= h_ff[i][0];
         o_ff[0][3+i] <= h_ff[i][1];
         o_ff[0][6+i] <= sat32(-(sx(h_ff[i][0]) + sx(h_ff[i][1])));
      end
      eo_ff[0] <= e12_ff;
      for (int k = 1; k < TAIL; k++) begin
         o_ff[k] <= o_ff[k-1];
         eo_ff[k] <= eo_ff[k-1];
      end
   end
   assign rsp_grad_v0_x = o_ff[TAIL-1][0];
   assign rsp_grad_v0_y = o_ff[TAIL-1][1];
   assign rsp_grad_v0_z = o_ff[TAIL-1][2];
   assign rsp_grad_v1_x = o_ff[TAIL-1][3];
   assign rsp_grad_v1_y = o_ff[TAIL-1][4];
   assign rsp_grad_v1_z = o_ff[TAIL-1][5];
   assign rsp_grad_v2_x = o_ff[TAIL-1][6];
   assign rsp_grad_v2_y = o_ff[TAIL-1][7];
   assign rsp_grad_v2_z = o_ff[TAIL-1][8];
   assign rsp_elastic_energy = eo_ff[TAIL-1];
endmodule
`default_nettype wire

[hw/rtl/stvk_checker.sv]
// Port-level checker for the StVK unit, bound to the top level.
`default_nettype none
`include "stvk_triangle_energy_gradient_unit_assert.svh"
module stvk_checker (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_valid
);
   import stvk_pkg::*;
   `STVK_ASSERT_IMPL(a_never_busy, 1'b1, !busy, "busy raised")
   `STVK_ASSERT_IMPL(a_word_follows_start, $past(start && !busy, LATENCY) && !$past(reset, LATENCY), rsp_valid, "word lost")
   `STVK_ASSERT_IMPL(a_no_spurious_word, rsp_valid, $past(start && !busy, LATENCY), "word invented")
endmodule
bind stvk_triangle_energy_gradient_unit stvk_checker u_stvk_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid));
`default_nettype wire
